FILE: hdl/bwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_pkg
// Shared widths, register indexes and pipeline types for the barycentric
// weight block.
// ----------------------------------------------------------------------------
package bwt_pkg;

    localparam int COORD_W   = 16;  // Q12.4 coordinates
    localparam int WEIGHT_W  = 24;  // Q7.16 weights
    localparam int THR_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MAG_W     = SUM_W - 1;
    localparam int QUO_W     = WEIGHT_W + 1;  // weight bits plus one rounding bit
    localparam int LANES     = 3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN_MAG = {1'b1, {(WEIGHT_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_AX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CY   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP = 3'd6;

    // per-request flags that ride along the divider chain
    typedef struct packed {
        logic [LANES-1:0] neg;
        logic [LANES-1:0] sat;
        logic             degen;
    } t_lane_meta;

endpackage

FILE: hdl/barycentric_weights_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_weights_2d
// Barycentric weights u, v, w of a query point against a configured 2D
// triangle, by Cramer's rule and a chain of restoring-division cells.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  point     in         i_valid / o_stall   i_point_x, i_point_y
//  weights   out        o_valid / i_stall   o_weight_u/v/w, o_degenerate
//  config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
//  One request per cycle while the output is not stalled; the pipeline is
//  6 front stages, 25 division cells and the output register.
//  The division chain sets the length: one cell per quotient bit.
//  i_rst_n (synchronous) clears the config registers and all valid bits.
//  A stalled result holds the whole pipeline; o_stall rises only then.
// ----------------------------------------------------------------------------
module barycentric_weights_2d #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [bwt_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [bwt_pkg::CFG_DAT_W-1:0]           i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [bwt_pkg::COORD_W-1:0]      i_point_x,
    input  logic signed [bwt_pkg::COORD_W-1:0]      i_point_y,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [bwt_pkg::WEIGHT_W-1:0]     o_weight_u,
    output logic signed [bwt_pkg::WEIGHT_W-1:0]     o_weight_v,
    output logic signed [bwt_pkg::WEIGHT_W-1:0]     o_weight_w,
    output logic                                    o_degenerate
);
    import bwt_pkg::*;

    // remainder width: holds 2*|n|*2^F and |det|*2^QUO_W
    localparam int XW = MAG_W + WEIGHT_FRAC_BITS + 1;
    localparam int DW = MAG_W + QUO_W;
    localparam int RW = (XW > DW) ? XW : DW;

    logic signed [COORD_W-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [THR_W-1:0]          r_snap;
    logic                      w_adv;

    logic                c_valid [QUO_W+1];
    logic [RW-1:0]       c_den   [QUO_W+1];
    logic [RW-1:0]       c_rem   [QUO_W+1][LANES];
    logic [QUO_W-1:0]    c_quo   [QUO_W+1][LANES];
    t_lane_meta          c_meta  [QUO_W+1];

    logic [QUO_W-1:0]    w_rnd [LANES];
    logic [WEIGHT_W-1:0] w_mag [LANES];
    logic [WEIGHT_W-1:0] w_val [LANES];
    logic [WEIGHT_W-1:0] n_w;

    // advance everything unless a finished result is held by the consumer
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    // config write port; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0; r_ay <= '0; r_bx <= '0; r_by <= '0;
            r_cx <= '0; r_cy <= '0; r_snap <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AX:   r_ax <= i_cfg_data;
                REG_AY:   r_ay <= i_cfg_data;
                REG_BX:   r_bx <= i_cfg_data;
                REG_BY:   r_by <= i_cfg_data;
                REG_CX:   r_cx <= i_cfg_data;
                REG_CY:   r_cy <= i_cfg_data;
                REG_SNAP: r_snap <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    bwt_front #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
        .RW               (RW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_bx    (r_bx),
        .i_by    (r_by),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .o_valid (c_valid[0]),
        .o_den   (c_den[0]),
        .o_rem   (c_rem[0]),
        .o_meta  (c_meta[0])
    );

    // quotient registers start empty; each cell shifts in one bit
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            c_quo[0][k] = '0;
        end
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        bwt_div_cell #(.RW(RW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (c_valid[g]),
            .i_den   (c_den[g]),
            .i_rem   (c_rem[g]),
            .i_quo   (c_quo[g]),
            .i_meta  (c_meta[g]),
            .o_valid (c_valid[g+1]),
            .o_den   (c_den[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_quo   (c_quo[g+1]),
            .o_meta  (c_meta[g+1])
        );
    end

    // round half away from zero: the chain yields floor(2|n|*2^F/|d|)
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_rnd[k] = QUO_W'(({1'b0, c_quo[QUO_W][k]} + 1'b1) >> 1);
            if (c_meta[QUO_W].sat[k] || (w_rnd[k] > QUO_W'(WEIGHT_MIN_MAG))) begin
                w_mag[k] = WEIGHT_MIN_MAG;
            end else begin
                w_mag[k] = w_rnd[k][WEIGHT_W-1:0];
            end
            if (!c_meta[QUO_W].neg[k] && w_mag[k][WEIGHT_W-1]) begin
                w_mag[k] = WEIGHT_MAX;
            end
            w_val[k] = c_meta[QUO_W].neg[k] ? -w_mag[k] : w_mag[k];
        end
        // snap small w to zero, compared on the saturated magnitude
        n_w = (w_mag[2] < WEIGHT_W'(r_snap)) ? '0 : w_val[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= c_valid[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_degenerate <= c_meta[QUO_W].degen;
            o_weight_u   <= c_meta[QUO_W].degen ? '0 : w_val[0];
            o_weight_v   <= c_meta[QUO_W].degen ? '0 : w_val[1];
            o_weight_w   <= c_meta[QUO_W].degen ? '0 : n_w;
        end
    end

endmodule

FILE: hdl/bwt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_front
// Cramer's rule front end: differences, products, numerators, magnitudes,
// and the divider seed with its overflow precheck.
// ----------------------------------------------------------------------------
module bwt_front #(
    parameter int WEIGHT_FRAC_BITS = 16,
    parameter int RW = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_valid,
    input  logic signed [bwt_pkg::COORD_W-1:0]  i_px,
    input  logic signed [bwt_pkg::COORD_W-1:0]  i_py,
    input  logic signed [bwt_pkg::COORD_W-1:0]  i_ax,
    input  logic signed [bwt_pkg::COORD_W-1:0]  i_ay,
    input  logic signed [bwt_pkg::COORD_W-1:0]  i_bx,
    input  logic signed [bwt_pkg::COORD_W-1:0]  i_by,
    input  logic signed [bwt_pkg::COORD_W-1:0]  i_cx,
    input  logic signed [bwt_pkg::COORD_W-1:0]  i_cy,
    output logic                                o_valid,
    output logic [RW-1:0]                       o_den,
    output logic [RW-1:0]                       o_rem [bwt_pkg::LANES],
    output bwt_pkg::t_lane_meta                 o_meta
);
    import bwt_pkg::*;

    logic signed [DIFF_W-1:0] w_bcy, w_cbx, w_caym, w_acx, w_acy;
    logic signed [DIFF_W-1:0] r1_dx, r1_dy;
    logic signed [PROD_W-1:0] r2_p [6];
    logic signed [SUM_W-1:0]  r3_nu, r3_nv, r3_det;
    logic signed [SUM_W-1:0]  r4_n [LANES];
    logic signed [SUM_W-1:0]  r4_det;
    logic [MAG_W-1:0]         r5_mag [LANES];
    logic [MAG_W-1:0]         r5_dmag;
    logic [LANES-1:0]         r5_neg;
    logic                     r5_degen;
    logic [5:0]               r_v;
    logic [RW-1:0]            w_x [LANES];
    logic [RW-1:0]            w_dq;

    assign w_bcy  = $signed({i_by[COORD_W-1], i_by}) - $signed({i_cy[COORD_W-1], i_cy});
    assign w_cbx  = $signed({i_cx[COORD_W-1], i_cx}) - $signed({i_bx[COORD_W-1], i_bx});
    assign w_caym = $signed({i_cy[COORD_W-1], i_cy}) - $signed({i_ay[COORD_W-1], i_ay});
    assign w_acx  = $signed({i_ax[COORD_W-1], i_ax}) - $signed({i_cx[COORD_W-1], i_cx});
    assign w_acy  = $signed({i_ay[COORD_W-1], i_ay}) - $signed({i_cy[COORD_W-1], i_cy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_dx <= $signed({i_px[COORD_W-1], i_px}) - $signed({i_cx[COORD_W-1], i_cx});
            r1_dy <= $signed({i_py[COORD_W-1], i_py}) - $signed({i_cy[COORD_W-1], i_cy});
            r2_p[0] <= r1_dx * w_bcy;
            r2_p[1] <= w_cbx * r1_dy;
            r2_p[2] <= r1_dx * w_caym;
            r2_p[3] <= w_acx * r1_dy;
            r2_p[4] <= w_acx * w_bcy;
            r2_p[5] <= w_cbx * w_acy;
            r3_nu  <= SUM_W'(r2_p[0]) + SUM_W'(r2_p[1]);
            r3_nv  <= SUM_W'(r2_p[2]) + SUM_W'(r2_p[3]);
            r3_det <= SUM_W'(r2_p[4]) + SUM_W'(r2_p[5]);
            r4_n[0] <= r3_nu;
            r4_n[1] <= r3_nv;
            r4_n[2] <= r3_det - r3_nu - r3_nv;
            r4_det  <= r3_det;
            for (int k = 0; k < LANES; k++) begin
                r5_mag[k] <= MAG_W'(r4_n[k][SUM_W-1] ? -r4_n[k] : r4_n[k]);
                r5_neg[k] <= r4_n[k][SUM_W-1] ^ r4_det[SUM_W-1];
            end
            r5_dmag  <= MAG_W'(r4_det[SUM_W-1] ? -r4_det : r4_det);
            r5_degen <= (r4_det == '0);
        end
    end

    // scaled numerator 2*n*2^F against den*2^QUO_W: at or above, the weight saturates
    assign w_dq = RW'(r5_dmag) << QUO_W;
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_x[k] = RW'(r5_mag[k]) << (WEIGHT_FRAC_BITS + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_den <= RW'(r5_dmag) << (QUO_W - 1);
            for (int k = 0; k < LANES; k++) begin
                o_rem[k]      <= w_x[k];
                o_meta.sat[k] <= (w_x[k] >= w_dq);
            end
            o_meta.neg   <= r5_neg;
            o_meta.degen <= r5_degen;
        end
    end

    assign o_valid = r_v[5];

endmodule

FILE: hdl/bwt_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_div_cell
// One restoring-division cell: retires one quotient bit on all three lanes
// and hands the halved divisor to the next cell.
// ----------------------------------------------------------------------------
module bwt_div_cell #(
    parameter int RW = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [RW-1:0]               i_den,
    input  logic [RW-1:0]               i_rem [bwt_pkg::LANES],
    input  logic [bwt_pkg::QUO_W-1:0]   i_quo [bwt_pkg::LANES],
    input  bwt_pkg::t_lane_meta         i_meta,
    output logic                        o_valid,
    output logic [RW-1:0]               o_den,
    output logic [RW-1:0]               o_rem [bwt_pkg::LANES],
    output logic [bwt_pkg::QUO_W-1:0]   o_quo [bwt_pkg::LANES],
    output bwt_pkg::t_lane_meta         o_meta
);
    import bwt_pkg::*;

    logic [LANES-1:0] w_ge;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_ge[k] = (i_rem[k] >= i_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_den  <= i_den >> 1;
            o_meta <= i_meta;
            for (int k = 0; k < LANES; k++) begin
                o_rem[k] <= w_ge[k] ? i_rem[k] - i_den : i_rem[k];
                o_quo[k] <= {i_quo[k][QUO_W-2:0], w_ge[k]};
            end
        end
    end

endmodule

FILE: hdl/bwt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_checker
// Port-level checks for the barycentric weight block, bound to the top.
// ----------------------------------------------------------------------------
module bwt_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [bwt_pkg::WEIGHT_W-1:0]  o_weight_u,
    input logic signed [bwt_pkg::WEIGHT_W-1:0]  o_weight_v,
    input logic signed [bwt_pkg::WEIGHT_W-1:0]  o_weight_w,
    input logic                                 o_degenerate
);
    import bwt_pkg::*;

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_weight_u) && $stable(o_weight_v)
            && $stable(o_weight_w) && $stable(o_degenerate))
        else $error("held result changed");

    // input back-pressure only comes from a held result
    a_stall: assert property (@(posedge i_clk) o_stall |-> o_valid && i_stall)
        else $error("stall without held result");

    // a degenerate triangle gives all-zero weights
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_weight_u == '0 && o_weight_v == '0
            && o_weight_w == '0)
        else $error("degenerate with nonzero weights");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind barycentric_weights_2d bwt_checker u_bwt_checker (.*);
